FILE: src/rv32m_mul_div_unit_top_macros.svh
// Assertion macros for the RV32M multiply/divide unit.
`ifndef RV32M_MUL_DIV_UNIT_TOP_MACROS_SVH
`define RV32M_MUL_DIV_UNIT_TOP_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define MDU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define MDU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: src/mdu_pkg.sv
// Shared types and constants for the RV32M multiply/divide unit.
package mdu_pkg;
  localparam int unsigned XLEN = 32;
  localparam logic [2:0] OP_MUL    = 3'd0;
  localparam logic [2:0] OP_MULH   = 3'd1;
  localparam logic [2:0] OP_MULHSU = 3'd2;
  localparam logic [2:0] OP_MULHU  = 3'd3;
  localparam logic [2:0] OP_DIV    = 3'd4;
  localparam logic [2:0] OP_DIVU   = 3'd5;
  localparam logic [2:0] OP_REM    = 3'd6;
  localparam logic [2:0] OP_REMU   = 3'd7;

  // Data carried by one cell of the chain.
  typedef struct packed {
    logic            is_div;
    logic            hi_sel;
    logic            rem_sel;
    logic            neg_res;
    logic            special;
    logic [XLEN-1:0] special_val;
    logic [2*XLEN-1:0] acc;   // mul: product partial; div: {rem, quotient/dividend}
    logic [XLEN-1:0] opb;     // mul: multiplier bits remaining; div: divisor magnitude
    logic [XLEN:0]   mcand;   // mul: sign-extended multiplicand
  } cell_t;
endpackage

FILE: src/mdu_cell.sv
// One step cell: one radix-2 multiply or restoring divide step.
module mdu_cell import mdu_pkg::*; #(
  parameter int unsigned StepIdx = 0
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  cell_t data_i,
  output logic  valid_o,
  output cell_t data_o
);
  cell_t            data_d, data_q;
  logic             valid_q;
  logic [XLEN:0]    sum;
  logic [XLEN:0]    trial;
  logic [XLEN-1:0]  rem_sh;
  logic             hi_ext;

  always_comb begin
    data_d = data_i;
    sum    = '0;
    trial  = '0;
    rem_sh = '0;
    hi_ext = 1'b0;
    if (data_i.is_div) begin
      rem_sh = {data_i.acc[2*XLEN-2:XLEN], data_i.acc[XLEN-1]};
      trial  = {1'b0, rem_sh} - {1'b0, data_i.opb};
      if (!trial[XLEN] || data_i.acc[2*XLEN-1]) begin
        data_d.acc = {trial[XLEN-1:0], data_i.acc[XLEN-2:0], 1'b1};
      end else begin
        data_d.acc = {rem_sh, data_i.acc[XLEN-2:0], 1'b0};
      end
    end else begin
      // acc high half is signed only for a signed multiplicand; shift right each step
      hi_ext = data_i.mcand[XLEN] & data_i.acc[2*XLEN-1];
      if (data_i.opb[0]) begin
        if (StepIdx == XLEN - 1 && data_i.neg_res) begin
          sum = {hi_ext, data_i.acc[2*XLEN-1:XLEN]} - data_i.mcand;
        end else begin
          sum = {hi_ext, data_i.acc[2*XLEN-1:XLEN]} + data_i.mcand;
        end
      end else begin
        sum = {hi_ext, data_i.acc[2*XLEN-1:XLEN]};
      end
      data_d.acc = {sum, data_i.acc[XLEN-1:1]};
      data_d.opb = {1'b0, data_i.opb[XLEN-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

FILE: src/rv32m_mul_div_unit_top.sv
// Top level of the pipelined RV32M multiply/divide unit.
// Channel | Signals                                                | Dir
// request | in_valid_i in_ready_o operation_i operand_a_i operand_b_i | in
// result  | out_valid_o out_ready_i result_o                        | out
// Pipeline: 32 step cells, then an output stage.
// Throughput: one request per cycle; the chain advances when the output is free.
// Reset clears all valid bits; payload is not reset.
// A stalled output freezes the whole chain; input ready follows that.
`include "rv32m_mul_div_unit_top_macros.svh"
module rv32m_mul_div_unit_top import mdu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  operation_i,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] result_o
);
  cell_t            init_c;
  cell_t            chain_d [XLEN+1];
  logic             chain_v [XLEN+1];
  logic             adv;
  logic             out_valid_q;
  logic [XLEN-1:0]  result_q, res_d;
  logic             a_neg, b_neg, a_sgn, b_sgn;
  logic [XLEN-1:0]  a_mag, b_mag;
  cell_t            fin;
  logic [XLEN-1:0]  q_val, r_val;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  always_comb begin
    init_c = '0;
    a_sgn  = (operation_i == OP_MULH) || (operation_i == OP_MULHSU) ||
             (operation_i == OP_DIV) || (operation_i == OP_REM);
    b_sgn  = (operation_i == OP_MULH) || (operation_i == OP_DIV) || (operation_i == OP_REM);
    a_neg  = a_sgn && operand_a_i[XLEN-1];
    b_neg  = b_sgn && operand_b_i[XLEN-1];
    a_mag  = a_neg ? (~operand_a_i + 1'b1) : operand_a_i;
    b_mag  = b_neg ? (~operand_b_i + 1'b1) : operand_b_i;
    init_c.is_div  = operation_i[2];
    init_c.hi_sel  = operation_i != OP_MUL;
    init_c.rem_sel = operation_i[1];
    if (operation_i[2]) begin
      init_c.neg_res = operation_i[1] ? a_neg : (a_neg ^ b_neg);
      init_c.acc     = {{XLEN{1'b0}}, a_mag};
      init_c.opb     = b_mag;
      if (operand_b_i == '0) begin
        init_c.special     = 1'b1;
        init_c.special_val = operation_i[1] ? operand_a_i : '1;
      end
    end else begin
      // signed b: final cell subtracts when b's sign bit is set
      init_c.neg_res = b_neg;
      init_c.mcand   = {a_neg, operand_a_i};
      init_c.opb     = operand_b_i;
    end
  end

  assign chain_d[0] = init_c;
  assign chain_v[0] = in_valid_i;

  for (genvar g = 0; g < XLEN; g++) begin : g_cell
    mdu_cell #(.StepIdx(g)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (chain_v[g]),
      .data_i  (chain_d[g]),
      .valid_o (chain_v[g+1]),
      .data_o  (chain_d[g+1])
    );
  end

  assign fin   = chain_d[XLEN];
  assign q_val = fin.neg_res ? (~fin.acc[XLEN-1:0] + 1'b1) : fin.acc[XLEN-1:0];
  assign r_val = fin.neg_res ? (~fin.acc[2*XLEN-1:XLEN] + 1'b1) : fin.acc[2*XLEN-1:XLEN];

  always_comb begin
    if (fin.is_div) begin
      if (fin.special) res_d = fin.special_val;
      else res_d = fin.rem_sel ? r_val : q_val;
    end else begin
      res_d = fin.hi_sel ? fin.acc[2*XLEN-1:XLEN] : fin.acc[XLEN-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= chain_v[XLEN];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      result_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

  `MDU_ASSERT_IMP(a_ready_free, clk_i, rst_ni, !out_valid_o, in_ready_o, "ready low, empty out")
  `MDU_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(result_o), "stall moved")
  `MDU_ASSERT_NEXT(a_drain, clk_i, rst_ni, in_ready_o && chain_v[XLEN], out_valid_o, "chain output lost")
endmodule
